@@ rtl/c8_pkg.sv @@
// Shared types, codes and constants of the CHIP-8 instruction core.
// No dependencies; imported by every module of the core.
package c8_pkg;

    localparam int MEMORY_BYTES    = 4096;
    localparam int ADDR_W          = $clog2(MEMORY_BYTES);
    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCREEN_WIDTH    = 64;
    localparam int SCREEN_HEIGHT   = 32;
    localparam int ROW_W           = $clog2(SCREEN_HEIGHT);
    localparam int COL_W           = $clog2(SCREEN_WIDTH);
    localparam int FONT_BYTES      = 80;
    localparam int FONT_IDX_W      = $clog2(FONT_BYTES);

    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    // request commands
    localparam logic [1:0] CMD_WRITE_MEM = 2'd0;
    localparam logic [1:0] CMD_SET_KEY   = 2'd1;
    localparam logic [1:0] CMD_EXECUTE   = 2'd2;
    localparam logic [1:0] CMD_READ_ROW  = 2'd3;

    // result status
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_WAIT_KEY = 2'd1;
    localparam logic [1:0] ST_BAD_OP   = 2'd2;

    // register index (paddr[2])
    localparam logic REG_PROGRAM_START = 1'b0;

    // shared unit operations
    typedef logic [2:0] alu_op_t;
    localparam alu_op_t ALU_ADD   = 3'd0;
    localparam alu_op_t ALU_SUB   = 3'd1;
    localparam alu_op_t ALU_AND   = 3'd2;
    localparam alu_op_t ALU_OR    = 3'd3;
    localparam alu_op_t ALU_XOR   = 3'd4;
    localparam alu_op_t ALU_SHR   = 3'd5;
    localparam alu_op_t ALU_SHL   = 3'd6;
    localparam alu_op_t ALU_PASSB = 3'd7;

    typedef struct packed {
        alu_op_t     op;
        logic [15:0] a;
        logic [15:0] b;
    } alu_in_t;

    typedef struct packed {
        logic [16:0] sum;
        logic        ge;
        logic        eq;
    } alu_out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] mem_address;
        logic [7:0]        mem_data;
        logic [3:0]        key_number;
        logic              key_down;
        logic [7:0]        random_byte;
        logic [ROW_W-1:0]  row_select;
    } c8_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]       program_counter;
        logic [1:0]              status;
        logic                    display_touched;
        logic                    beep;
        logic [SCREEN_WIDTH-1:0] row_pixels;
    } c8_res_t;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

@@ rtl/c8_alu.sv @@
// Shared arithmetic unit: add, subtract, logic and shifts with compare flags.
// Depends on c8_pkg.
module c8_alu (
    input  c8_pkg::alu_in_t  alu_in,
    output c8_pkg::alu_out_t alu_out
);
    import c8_pkg::*;

    always_comb begin
        alu_out.ge = (alu_in.a >= alu_in.b);
        alu_out.eq = (alu_in.a == alu_in.b);
        unique case (alu_in.op)
            ALU_ADD:   alu_out.sum = {1'b0, alu_in.a} + {1'b0, alu_in.b};
            ALU_SUB:   alu_out.sum = {1'b0, alu_in.a} - {1'b0, alu_in.b};
            ALU_AND:   alu_out.sum = {1'b0, alu_in.a & alu_in.b};
            ALU_OR:    alu_out.sum = {1'b0, alu_in.a | alu_in.b};
            ALU_XOR:   alu_out.sum = {1'b0, alu_in.a ^ alu_in.b};
            ALU_SHR:   alu_out.sum = {2'b00, alu_in.a[15:1]};
            ALU_SHL:   alu_out.sum = {alu_in.a, 1'b0};
            ALU_PASSB: alu_out.sum = {1'b0, alu_in.b};
        endcase
    end

endmodule

@@ rtl/c8_ram.sv @@
// 4 KiB byte memory, one write and one registered read port, with a
// clearing pass after reset that loads the font. Depends on c8_pkg.
module c8_ram (
    input  logic             aclk,
    input  logic             aresetn,
    input  c8_pkg::ram_req_t ram_req,
    output logic [7:0]       rdata,
    output logic             clearing
);
    import c8_pkg::*;

    localparam int CLR_W = ADDR_W + 1;

    logic [7:0]       mem [MEMORY_BYTES];
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [7:0]       rdata_reg;
    logic [7:0]       init_byte;

    assign clearing = ~clr_cnt_reg[CLR_W-1];
    assign rdata    = rdata_reg;

    // font in the low bytes, zero elsewhere
    always_comb begin
        if (clr_cnt_reg[ADDR_W-1:0] < ADDR_W'(FONT_BYTES)) begin
            init_byte = FONT_ROM[clr_cnt_reg[FONT_IDX_W-1:0]];
        end else begin
            init_byte = 8'h00;
        end
    end

    // clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (clearing) begin
            mem[clr_cnt_reg[ADDR_W-1:0]] <= init_byte;
        end else if (ram_req.we) begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        rdata_reg <= mem[ram_req.raddr];
    end

endmodule

@@ rtl/c8_core.sv @@
// Instruction sequencer: fetch, decode and multi-cycle execution of one
// request, holding the machine state. Depends on c8_pkg, c8_alu, c8_ram.
module c8_core #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  c8_pkg::c8_req_t           req,
    output logic                      ready,
    input  logic                      cfg_we,
    input  logic [c8_pkg::ADDR_W-1:0] cfg_pc,
    output logic                      res_valid,
    input  logic                      res_ready,
    output c8_pkg::c8_res_t           res
);
    import c8_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_FETCH_HI  = 5'd1;
    localparam logic [4:0] S_FETCH_LO  = 5'd2;
    localparam logic [4:0] S_READ_X    = 5'd3;
    localparam logic [4:0] S_READ_Y    = 5'd4;
    localparam logic [4:0] S_EXEC      = 5'd5;
    localparam logic [4:0] S_DRAW_ADDR = 5'd6;
    localparam logic [4:0] S_DRAW_DATA = 5'd7;
    localparam logic [4:0] S_BCD_H     = 5'd8;
    localparam logic [4:0] S_BCD_T     = 5'd9;
    localparam logic [4:0] S_BCD_W0    = 5'd10;
    localparam logic [4:0] S_BCD_W1    = 5'd11;
    localparam logic [4:0] S_BCD_W2    = 5'd12;
    localparam logic [4:0] S_STORE     = 5'd13;
    localparam logic [4:0] S_LOAD_ADDR = 5'd14;
    localparam logic [4:0] S_LOAD_DATA = 5'd15;
    localparam logic [4:0] S_IADV      = 5'd16;
    localparam logic [4:0] S_DONE      = 5'd17;

    // opcode families
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ARITH   = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;
    localparam logic [3:0] OP_RND     = 4'hC;
    localparam logic [3:0] OP_DRAW    = 4'hD;
    localparam logic [3:0] OP_KEY     = 4'hE;
    localparam logic [3:0] OP_MISC    = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // arithmetic sub-codes
    localparam logic [3:0] AR_MOV = 4'h0;
    localparam logic [3:0] AR_OR  = 4'h1;
    localparam logic [3:0] AR_AND = 4'h2;
    localparam logic [3:0] AR_XOR = 4'h3;
    localparam logic [3:0] AR_ADD = 4'h4;
    localparam logic [3:0] AR_SUB = 4'h5;
    localparam logic [3:0] AR_SHR = 4'h6;
    localparam logic [3:0] AR_RSB = 4'h7;
    localparam logic [3:0] AR_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN_SKIP = 8'h9E;
    localparam logic [7:0] KEY_UP_SKIP   = 8'hA1;

    localparam logic [7:0] FX_GET_DT  = 8'h07;
    localparam logic [7:0] FX_WAITKEY = 8'h0A;
    localparam logic [7:0] FX_SET_DT  = 8'h15;
    localparam logic [7:0] FX_SET_ST  = 8'h18;
    localparam logic [7:0] FX_ADD_I   = 8'h1E;
    localparam logic [7:0] FX_FONT    = 8'h29;
    localparam logic [7:0] FX_BCD     = 8'h33;
    localparam logic [7:0] FX_STORE   = 8'h55;
    localparam logic [7:0] FX_LOAD    = 8'h65;

    localparam logic [3:0] VF = 4'hF;

    logic [4:0]              state_reg;
    c8_req_t                 req_reg;
    logic [ADDR_W-1:0]       pc_reg;
    logic [ADDR_W-1:0]       next_pc_reg;
    logic [15:0]             op_reg;
    logic [7:0]              vx_reg;
    logic [7:0]              vy_reg;
    logic [7:0]              v_reg [16];
    logic [15:0]             i_reg;
    logic [ADDR_W-1:0]       stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]         sp_reg;
    logic [7:0]              delay_reg;
    logic [7:0]              sound_reg;
    logic [15:0]             key_reg;
    logic [SCREEN_WIDTH-1:0] fb_reg [SCREEN_HEIGHT];
    logic [3:0]              cnt_reg;
    logic                    hit_reg;
    logic [COL_W-1:0]        sx_reg;
    logic [ROW_W-1:0]        sy_reg;
    logic [7:0]              rem_reg;
    logic [3:0]              hund_reg;
    logic [3:0]              tens_reg;
    logic [1:0]              status_reg;
    logic                    touched_reg;

    logic [3:0]              op_fam, op_x, op_y, op_n;
    logic [7:0]              op_nn;
    logic [ADDR_W-1:0]       op_nnn;
    logic [3:0]              v_raddr;
    logic [7:0]              v_rdata;
    logic [ROW_W:0]          draw_row;
    logic [ROW_W-1:0]        fb_idx;
    logic [SCREEN_WIDTH-1:0] fb_row;
    logic [SCREEN_WIDTH-1:0] draw_mask;
    logic [3:0]              first_key;
    logic [SP_W-1:0]         sp_inc, sp_dec;
    logic [ADDR_W-1:0]       alu_addr;
    logic                    is_exec;
    logic                    clearing;
    logic [7:0]              ram_rdata;
    ram_req_t                ram_req;
    alu_in_t                 alu_in;
    alu_out_t                alu_out;

    c8_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    c8_ram u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ram_req  (ram_req),
        .rdata    (ram_rdata),
        .clearing (clearing)
    );

    // instruction fields
    assign op_fam = op_reg[15:12];
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_nn  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];

    assign is_exec  = (req_reg.command == CMD_EXECUTE);
    assign ready    = (state_reg == S_IDLE) && !clearing;
    assign alu_addr = alu_out.sum[ADDR_W-1:0];
    assign sp_inc   = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
    assign sp_dec   = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;

    // single read port on the data registers
    always_comb begin
        unique case (state_reg)
            S_READ_Y: v_raddr = (op_fam == OP_JP_V0) ? 4'h0 : op_y;
            S_STORE:  v_raddr = cnt_reg;
            default:  v_raddr = op_x;
        endcase
    end
    assign v_rdata = v_reg[v_raddr];

    // frame buffer row port and sprite mask
    assign draw_row  = {1'b0, sy_reg} + {2'b00, cnt_reg};
    assign fb_idx    = (state_reg == S_DRAW_DATA) ? draw_row[ROW_W-1:0] : req_reg.row_select;
    assign fb_row    = fb_reg[fb_idx];
    assign draw_mask = {ram_rdata, {(SCREEN_WIDTH-8){1'b0}}} >> sx_reg;

    // lowest pressed key
    always_comb begin
        first_key = 4'h0;
        for (int k = 15; k >= 0; k--) begin
            if (key_reg[k]) begin
                first_key = 4'(k);
            end
        end
    end

    // operand selection for the shared unit
    always_comb begin
        alu_in.op = ALU_ADD;
        alu_in.a  = i_reg;
        alu_in.b  = {12'h000, cnt_reg};
        unique case (state_reg)
            S_EXEC: begin
                unique case (op_fam)
                    OP_SE_IMM, OP_SNE_IMM: begin
                        alu_in.a = {8'h00, vx_reg};
                        alu_in.b = {8'h00, op_nn};
                    end
                    OP_ADD_IMM: begin
                        alu_in.a = {8'h00, vx_reg};
                        alu_in.b = {8'h00, op_nn};
                    end
                    OP_ARITH: begin
                        alu_in.a = {8'h00, vx_reg};
                        alu_in.b = {8'h00, vy_reg};
                        unique case (op_n)
                            AR_MOV:  alu_in.op = ALU_PASSB;
                            AR_OR:   alu_in.op = ALU_OR;
                            AR_AND:  alu_in.op = ALU_AND;
                            AR_XOR:  alu_in.op = ALU_XOR;
                            AR_SUB:  alu_in.op = ALU_SUB;
                            AR_SHR:  alu_in.op = ALU_SHR;
                            AR_SHL:  alu_in.op = ALU_SHL;
                            AR_RSB: begin
                                alu_in.op = ALU_SUB;
                                alu_in.a  = {8'h00, vy_reg};
                                alu_in.b  = {8'h00, vx_reg};
                            end
                            default: alu_in.op = ALU_ADD;
                        endcase
                    end
                    OP_JP_V0: begin
                        alu_in.a = {4'h0, op_nnn};
                        alu_in.b = {8'h00, vy_reg};
                    end
                    OP_RND: begin
                        alu_in.op = ALU_AND;
                        alu_in.a  = {8'h00, req_reg.random_byte};
                        alu_in.b  = {8'h00, op_nn};
                    end
                    OP_MISC: begin
                        if (op_nn == FX_FONT) begin
                            alu_in.a = {10'h000, vx_reg[3:0], 2'b00};
                            alu_in.b = {12'h000, vx_reg[3:0]};
                        end else begin
                            alu_in.a = i_reg;
                            alu_in.b = {8'h00, vx_reg};
                        end
                    end
                    default: begin
                        alu_in.a = {8'h00, vx_reg};
                        alu_in.b = {8'h00, vy_reg};
                    end
                endcase
            end
            S_BCD_H: begin
                alu_in.op = ALU_SUB;
                alu_in.a  = {8'h00, rem_reg};
                alu_in.b  = 16'd100;
            end
            S_BCD_T: begin
                alu_in.op = ALU_SUB;
                alu_in.a  = {8'h00, rem_reg};
                alu_in.b  = 16'd10;
            end
            S_BCD_W0: alu_in.b = 16'd0;
            S_BCD_W1: alu_in.b = 16'd1;
            S_BCD_W2: alu_in.b = 16'd2;
            S_IADV:   alu_in.b = {11'h000, {1'b0, op_x} + 5'd1};
            default:  alu_in.b = {12'h000, cnt_reg};
        endcase
    end

    // memory port
    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.waddr = alu_addr;
        ram_req.wdata = 8'h00;
        ram_req.raddr = alu_addr;
        unique case (state_reg)
            S_IDLE: begin
                ram_req.we    = start && (req.command == CMD_WRITE_MEM);
                ram_req.waddr = req.mem_address;
                ram_req.wdata = req.mem_data;
            end
            S_FETCH_HI: ram_req.raddr = pc_reg;
            S_FETCH_LO: ram_req.raddr = pc_reg + 1'b1;
            S_BCD_W0: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = {4'h0, hund_reg};
            end
            S_BCD_W1: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = {4'h0, tens_reg};
            end
            S_BCD_W2: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = rem_reg;
            end
            S_STORE: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = v_rdata;
            end
            default: ram_req.we = 1'b0;
        endcase
    end

    // result of the request in progress
    assign res_valid           = (state_reg == S_DONE);
    assign res.program_counter = (is_exec && status_reg == ST_DONE) ? next_pc_reg : pc_reg;
    assign res.status          = status_reg;
    assign res.display_touched = touched_reg;
    assign res.beep            = is_exec && (sound_reg == 8'd1);
    assign res.row_pixels      = (req_reg.command == CMD_READ_ROW) ? fb_row : '0;

    // sequencer and machine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= PC_RESET;
            i_reg       <= '0;
            sp_reg      <= '0;
            delay_reg   <= '0;
            sound_reg   <= '0;
            key_reg     <= '0;
            status_reg  <= ST_DONE;
            touched_reg <= 1'b0;
            req_reg     <= '0;
            for (int r = 0; r < 16; r++) begin
                v_reg[r] <= '0;
            end
            for (int s = 0; s < STACK_DEPTH; s++) begin
                stack_reg[s] <= '0;
            end
            for (int f = 0; f < SCREEN_HEIGHT; f++) begin
                fb_reg[f] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_we) begin
                        pc_reg <= cfg_pc;
                    end
                    if (start) begin
                        req_reg     <= req;
                        status_reg  <= ST_DONE;
                        touched_reg <= 1'b0;
                        if (req.command == CMD_SET_KEY) begin
                            key_reg[req.key_number] <= req.key_down;
                        end
                        state_reg <= (req.command == CMD_EXECUTE) ? S_FETCH_HI : S_DONE;
                    end
                end
                S_FETCH_HI: state_reg <= S_FETCH_LO;
                S_FETCH_LO: begin
                    op_reg[15:8] <= ram_rdata;
                    state_reg    <= S_READ_X;
                end
                S_READ_X: begin
                    op_reg[7:0] <= ram_rdata;
                    vx_reg      <= v_rdata;
                    state_reg   <= S_READ_Y;
                end
                S_READ_Y: begin
                    vy_reg    <= v_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    next_pc_reg <= pc_reg + 12'd2;
                    state_reg   <= S_DONE;
                    unique case (op_fam)
                        OP_SYS: begin
                            if (op_reg == OP_CLS) begin
                                for (int f = 0; f < SCREEN_HEIGHT; f++) begin
                                    fb_reg[f] <= '0;
                                end
                                touched_reg <= 1'b1;
                            end else if (op_reg == OP_RET) begin
                                sp_reg      <= sp_dec;
                                next_pc_reg <= stack_reg[sp_dec] + 12'd2;
                            end else begin
                                status_reg <= ST_BAD_OP;
                            end
                        end
                        OP_JP: next_pc_reg <= op_nnn;
                        OP_CALL: begin
                            stack_reg[sp_reg] <= pc_reg;
                            sp_reg            <= sp_inc;
                            next_pc_reg       <= op_nnn;
                        end
                        OP_SE_IMM, OP_SE_REG: begin
                            if (alu_out.eq) next_pc_reg <= pc_reg + 12'd4;
                        end
                        OP_SNE_IMM, OP_SNE_REG: begin
                            if (!alu_out.eq) next_pc_reg <= pc_reg + 12'd4;
                        end
                        OP_LD_IMM:  v_reg[op_x] <= op_nn;
                        OP_ADD_IMM: v_reg[op_x] <= alu_out.sum[7:0];
                        OP_ARITH: begin
                            unique case (op_n)
                                AR_MOV, AR_OR, AR_AND, AR_XOR: begin
                                    v_reg[op_x] <= alu_out.sum[7:0];
                                end
                                AR_ADD, AR_SHL: begin
                                    v_reg[op_x] <= alu_out.sum[7:0];
                                    v_reg[VF]   <= {7'h00, alu_out.sum[8]};
                                end
                                AR_SUB, AR_RSB: begin
                                    v_reg[op_x] <= alu_out.sum[7:0];
                                    v_reg[VF]   <= {7'h00, alu_out.ge};
                                end
                                AR_SHR: begin
                                    v_reg[op_x] <= alu_out.sum[7:0];
                                    v_reg[VF]   <= {7'h00, vx_reg[0]};
                                end
                                default: status_reg <= ST_BAD_OP;
                            endcase
                        end
                        OP_LD_I:  i_reg <= {4'h0, op_nnn};
                        OP_JP_V0: next_pc_reg <= alu_addr;
                        OP_RND:   v_reg[op_x] <= alu_out.sum[7:0];
                        OP_DRAW: begin
                            sx_reg      <= vx_reg[COL_W-1:0];
                            sy_reg      <= vy_reg[ROW_W-1:0];
                            cnt_reg     <= '0;
                            hit_reg     <= 1'b0;
                            touched_reg <= 1'b1;
                            state_reg   <= S_DRAW_ADDR;
                        end
                        OP_KEY: begin
                            if (op_nn == KEY_DOWN_SKIP) begin
                                if (key_reg[vx_reg[3:0]]) next_pc_reg <= pc_reg + 12'd4;
                            end else if (op_nn == KEY_UP_SKIP) begin
                                if (!key_reg[vx_reg[3:0]]) next_pc_reg <= pc_reg + 12'd4;
                            end else begin
                                status_reg <= ST_BAD_OP;
                            end
                        end
                        OP_MISC: begin
                            unique case (op_nn)
                                FX_GET_DT: v_reg[op_x] <= delay_reg;
                                FX_WAITKEY: begin
                                    if (|key_reg) begin
                                        v_reg[op_x] <= {4'h0, first_key};
                                    end else begin
                                        status_reg <= ST_WAIT_KEY;
                                    end
                                end
                                FX_SET_DT: delay_reg <= vx_reg;
                                FX_SET_ST: sound_reg <= vx_reg;
                                FX_ADD_I: begin
                                    i_reg     <= alu_out.sum[15:0];
                                    v_reg[VF] <= {7'h00, |alu_out.sum[16:ADDR_W]};
                                end
                                FX_FONT: i_reg <= alu_out.sum[15:0];
                                FX_BCD: begin
                                    rem_reg   <= vx_reg;
                                    hund_reg  <= '0;
                                    tens_reg  <= '0;
                                    state_reg <= S_BCD_H;
                                end
                                FX_STORE: begin
                                    cnt_reg   <= '0;
                                    state_reg <= S_STORE;
                                end
                                FX_LOAD: begin
                                    cnt_reg   <= '0;
                                    state_reg <= S_LOAD_ADDR;
                                end
                                default: status_reg <= ST_BAD_OP;
                            endcase
                        end
                    endcase
                end
                // sprite rows: address, then xor into the frame buffer
                S_DRAW_ADDR: begin
                    if ((cnt_reg >= op_n) || draw_row[ROW_W]) begin
                        v_reg[VF] <= {7'h00, hit_reg};
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DRAW_DATA;
                    end
                end
                S_DRAW_DATA: begin
                    if (|(fb_row & draw_mask)) hit_reg <= 1'b1;
                    fb_reg[fb_idx] <= fb_row ^ draw_mask;
                    cnt_reg        <= cnt_reg + 1'b1;
                    state_reg      <= S_DRAW_ADDR;
                end
                // decimal digits by repeated subtraction
                S_BCD_H: begin
                    if (alu_out.ge) begin
                        rem_reg  <= alu_out.sum[7:0];
                        hund_reg <= hund_reg + 1'b1;
                    end else begin
                        state_reg <= S_BCD_T;
                    end
                end
                S_BCD_T: begin
                    if (alu_out.ge) begin
                        rem_reg  <= alu_out.sum[7:0];
                        tens_reg <= tens_reg + 1'b1;
                    end else begin
                        state_reg <= S_BCD_W0;
                    end
                end
                S_BCD_W0: state_reg <= S_BCD_W1;
                S_BCD_W1: state_reg <= S_BCD_W2;
                S_BCD_W2: state_reg <= S_DONE;
                // block store and load
                S_STORE: begin
                    if (cnt_reg == op_x) begin
                        state_reg <= S_IADV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_LOAD_ADDR: state_reg <= S_LOAD_DATA;
                S_LOAD_DATA: begin
                    v_reg[cnt_reg] <= ram_rdata;
                    if (cnt_reg == op_x) begin
                        state_reg <= S_IADV;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_LOAD_ADDR;
                    end
                end
                S_IADV: begin
                    i_reg     <= alu_out.sum[15:0];
                    state_reg <= S_DONE;
                end
                // hand over the result, then commit pc and timers
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                        if (is_exec) begin
                            if (status_reg == ST_DONE) pc_reg <= next_pc_reg;
                            if (delay_reg != 8'd0) delay_reg <= delay_reg - 1'b1;
                            if (sound_reg != 8'd0) sound_reg <= sound_reg - 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/chip8_instruction_core_top.sv @@
// One request at a time, set by the sequencer and the single memory port.
// Reset: synchronous, active low; then a clearing pass loads the font into memory,
// during which no request is taken (register writes still are).
// Depends on c8_pkg and c8_core.
module chip8_instruction_core_top #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic [c8_pkg::ADDR_W-1:0]       s_mem_address,
    input  logic [7:0]                      s_mem_data,
    input  logic [3:0]                      s_key_number,
    input  logic                            s_key_down,
    input  logic [7:0]                      s_random_byte,
    input  logic [c8_pkg::ROW_W-1:0]        s_row_select,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [c8_pkg::ADDR_W-1:0]       m_program_counter,
    output logic [1:0]                      m_status,
    output logic                            m_display_touched,
    output logic                            m_beep,
    output logic [c8_pkg::SCREEN_WIDTH-1:0] m_row_pixels
);
    import c8_pkg::*;

    logic [ADDR_W-1:0] prog_start_reg;
    logic              cfg_we;
    logic              core_ready;
    logic              res_valid;
    logic              res_ready;
    c8_req_t           req;
    c8_res_t           res;
    c8_res_t           m_res_reg;
    logic              m_valid_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PROGRAM_START);
    assign prdata = (paddr[2] == REG_PROGRAM_START) ? {20'h00000, prog_start_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_start_reg <= PC_RESET;
        end else if (cfg_we) begin
            prog_start_reg <= pwdata[ADDR_W-1:0];
        end
    end

    // request side
    assign s_ready         = core_ready;
    assign req.command     = s_command;
    assign req.mem_address = s_mem_address;
    assign req.mem_data    = s_mem_data;
    assign req.key_number  = s_key_number;
    assign req.key_down    = s_key_down;
    assign req.random_byte = s_random_byte;
    assign req.row_select  = s_row_select;

    c8_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && core_ready),
        .req       (req),
        .ready     (core_ready),
        .cfg_we    (cfg_we),
        .cfg_pc    (pwdata[ADDR_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_program_counter = m_res_reg.program_counter;
    assign m_status          = m_res_reg.status;
    assign m_display_touched = m_res_reg.display_touched;
    assign m_beep            = m_res_reg.beep;
    assign m_row_pixels      = m_res_reg.row_pixels;

    // the sequencer is no longer ready after it takes a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while the sequencer stays ready");

    // status never carries an unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_DONE || m_status == ST_WAIT_KEY || m_status == ST_BAD_OP))
        else $error("result status out of range");

    // only completed instructions touch the display
    a_touch_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |-> !m_display_touched)
        else $error("display touched by a failed instruction");

endmodule
